@@ rtl/audio_fifo_adaptive_resampler_core_macros.svh @@
// Assertion macros for the resampler RTL; afar_back is the only user.
`ifndef AUDIO_FIFO_ADAPTIVE_RESAMPLER_CORE_MACROS_SVH
`define AUDIO_FIFO_ADAPTIVE_RESAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge outside reset.
`define AFAR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define AFAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define AFAR_ASSERT(label, clk, rst, prop, msg)
`define AFAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/afar_pkg.sv @@
package afar_pkg;

  localparam int SAMPLE_W = 10;
  localparam int TARGET_W = 11;
  localparam int STEP_W   = 17;
  localparam int PHASE_W  = 16;
  localparam int ADAPT_W  = 6;

  localparam logic [TARGET_W-1:0] TARGET_RESET  = 11'd800;
  localparam logic [STEP_W-1:0]   UNITY_STEP    = 17'd65536;
  localparam logic [7:0]          SILENCE_LEVEL = 8'd128;
  localparam int                  CORR_LIMIT    = 6553;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_UNDERRUN = 2'd2,
    STAT_PRIMING  = 2'd3
  } status_t;

  typedef struct packed {
    logic                       is_pull;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

endpackage

@@ rtl/afar_front.sv @@
module afar_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        dac_level,
  input  logic [7:0]        volume,
  input  logic              q_full,
  output logic              q_wr,
  output afar_pkg::item_t   q_item
);

  logic [3:0]         att;
  logic [4:0]         gain;
  logic signed [9:0]  scaled;
  logic signed [15:0] prod;
  logic signed [15:0] prod_adj;

  always_comb begin
    att      = (volume[7:4] < volume[3:0]) ? volume[7:4] : volume[3:0];
    gain     = 5'd16 - {1'b0, att};
    // center the level and scale by 4
    scaled   = signed'({dac_level - afar_pkg::SILENCE_LEVEL, 2'b00});
    prod     = scaled * signed'({1'b0, gain});
    // bias negatives so the shift truncates toward zero
    prod_adj = prod + (prod[15] ? 16'sd15 : 16'sd0);
    q_item.is_pull = req_type;
    q_item.sample  = prod_adj[13:4];
  end

  assign in_ready = !q_full;
  assign q_wr     = in_valid && !q_full;

endmodule

@@ rtl/afar_queue.sv @@
module afar_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  afar_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output afar_pkg::item_t rd_item
);

  afar_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic [1:0]      count_next;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_item = entries[rd_ptr];

  always_comb begin
    case ({wr, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

@@ rtl/afar_back.sv @@
`include "audio_fifo_adaptive_resampler_core_macros.svh"

module afar_back #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [10:0]             fill_target,
  input  logic                    q_valid,
  input  afar_pkg::item_t         q_item,
  output logic                    q_pop,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic signed [9:0]       res_sample,
  output afar_pkg::status_t       res_status
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(BUFFER_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_EXT = (IW+1)'(BUFFER_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD0  = 4'b0010,
    S_RD1  = 4'b0100,
    S_MUL  = 4'b1000
  } state_t;

  state_t            state;
  logic [IW-1:0]     write_index;
  logic [IW-1:0]     read_index;
  logic [IW-1:0]     fill;
  logic              playing;
  logic signed [9:0] held;
  logic [15:0]       phase;
  logic [16:0]       step;
  logic [5:0]        adapt_cnt;

  logic signed [9:0]  store [BUFFER_DEPTH];
  logic signed [9:0]  rdata;
  logic signed [9:0]  e0;
  logic signed [13:0] corr_r;
  logic signed [27:0] prod;

  logic [IW-1:0]      wr_plus1;
  logic [IW-1:0]      rd_plus1;
  logic [IW-1:0]      raddr;
  logic               slot_free;
  logic               full;
  logic               start;
  logic               play_now;
  logic               fill_lt2;
  logic               mem_we;
  logic               res_set;
  logic signed [IW+1:0] fdiff;
  logic signed [IW+4:0] corr8;
  logic signed [13:0]   corr_clamp;
  logic signed [18:0]   sdiff;
  logic signed [18:0]   sdiff_adj;
  logic signed [18:0]   step_sum;
  logic [17:0]          phase_sum;
  logic [1:0]           adv;
  logic [IW:0]          rd_adv;
  logic [IW:0]          rd_wrapped;
  logic signed [10:0]   ediff;
  logic signed [27:0]   prod_adj;
  logic signed [11:0]   interp_q;
  logic signed [11:0]   held_sum;
  logic [IW:0]          fill_chk;

  always_comb begin
    wr_plus1  = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
    rd_plus1  = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
    raddr     = (state == S_RD0) ? rd_plus1 : read_index;
    slot_free = !res_valid || res_ready;
    full      = (wr_plus1 == read_index);
    start     = (state == S_IDLE) && q_valid && slot_free;
    play_now  = playing || ((IW+1)'(fill) >= (IW+1)'(fill_target));
    fill_lt2  = (fill < IW'(2));
    mem_we    = start && !q_item.is_pull && !full;
    res_set   = (start && (!q_item.is_pull || !play_now || fill_lt2)) || (state == S_MUL);

    // rate correction, clamped
    fdiff = signed'((IW+2)'(fill)) - signed'((IW+2)'(fill_target));
    corr8 = signed'({fdiff, 3'b000});
    if (corr8 > (IW+5)'(afar_pkg::CORR_LIMIT)) begin
      corr_clamp = 14'(afar_pkg::CORR_LIMIT);
    end else if (corr8 < (IW+5)'(-afar_pkg::CORR_LIMIT)) begin
      corr_clamp = 14'(-afar_pkg::CORR_LIMIT);
    end else begin
      corr_clamp = corr8[13:0];
    end

    sdiff     = signed'({2'b00, afar_pkg::UNITY_STEP}) + 19'(corr_r)
                - signed'({2'b00, step});
    sdiff_adj = sdiff + (sdiff[18] ? 19'sd15 : 19'sd0);
    step_sum  = signed'({2'b00, step}) + (sdiff_adj >>> 4);

    phase_sum  = {2'b00, phase} + {1'b0, step};
    adv        = phase_sum[17:16];
    rd_adv     = {1'b0, read_index} + (IW+1)'(adv);
    rd_wrapped = (rd_adv >= DEPTH_EXT) ? rd_adv - DEPTH_EXT : rd_adv;

    ediff    = 11'(rdata) - 11'(e0);
    prod_adj = prod + (prod[27] ? 28'sd65535 : 28'sd0);
    interp_q = prod_adj[27:16];
    held_sum = 12'(e0) + interp_q;

    fill_chk = {1'b0, write_index} + ((write_index < read_index) ? DEPTH_EXT : '0)
               - {1'b0, read_index};
  end

  assign q_pop = start;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[write_index] <= q_item.sample;
    end
    rdata <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      read_index  <= '0;
      fill        <= '0;
      playing     <= 1'b0;
      held        <= '0;
      phase       <= '0;
      step        <= afar_pkg::UNITY_STEP;
      adapt_cnt   <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (!q_item.is_pull) begin
              if (!full) begin
                write_index <= wr_plus1;
                fill        <= fill + 1'b1;
              end
            end else if (!play_now || fill_lt2) begin
              playing <= play_now;
            end else begin
              playing <= 1'b1;
              state   <= S_RD0;
            end
          end
        end
        S_RD0: begin
          if (adapt_cnt == '0) begin
            step <= step_sum[16:0];
          end
          adapt_cnt <= adapt_cnt + 1'b1;
          state     <= S_RD1;
        end
        S_RD1: begin
          // advance the read side with the updated step
          phase      <= phase_sum[15:0];
          read_index <= rd_wrapped[IW-1:0];
          fill       <= fill - IW'(adv);
          state      <= S_MUL;
        end
        S_MUL: begin
          held  <= held_sum[9:0];
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        corr_r <= corr_clamp;
        if (start) begin
          if (!q_item.is_pull) begin
            res_sample <= '0;
            res_status <= full ? afar_pkg::STAT_FULL : afar_pkg::STAT_OK;
          end else if (!play_now) begin
            res_sample <= '0;
            res_status <= afar_pkg::STAT_PRIMING;
          end else begin
            res_sample <= held;
            res_status <= afar_pkg::STAT_UNDERRUN;
          end
        end
      end
      S_RD0: begin
        e0 <= rdata;
      end
      S_RD1: begin
        prod <= ediff * signed'({1'b0, phase});
      end
      S_MUL: begin
        res_sample <= held_sum[9:0];
        res_status <= afar_pkg::STAT_OK;
      end
      default: begin
        e0 <= e0;
      end
    endcase
  end

  `AFAR_ASSERT(a_fill_track, clk, rst, fill == fill_chk[IW-1:0], "fill count out of step with indexes")
  `AFAR_ASSERT(a_slot_empty, clk, rst, (state != S_IDLE) |-> !res_valid, "result slot busy during pull")
  `AFAR_ASSERT(a_step_range, clk, rst, (step >= 17'd58983) && (step <= 17'd72089), "phase step out of range")
  `AFAR_ASSERT_NEXT(a_playing_sticks, clk, rst, playing, playing, "playback flag cleared")

endmodule

@@ rtl/audio_fifo_adaptive_resampler_core.sv @@
// Adaptive-rate audio FIFO with linear interpolation. Push items are attenuated and written
// to a ring buffer of BUFFER_DEPTH entries; pull items return one sample, held at 0 until
// the fill first reaches fill_target, then read at a fractional rate that tracks that
// fill. A two-item queue sits in front of the engine, so input is taken while the engine
// works or a result waits. The engine ends a push or a priming or underrun pull in its
// idle state, and takes an interpolating pull through S_RD0, S_RD1 and S_MUL: its two
// buffer entries come one after the other through the single read port of the buffer
// memory, then the multiply and the final add each take a register stage. A new item
// starts once the result register is empty or being taken.
module audio_fifo_adaptive_resampler_core #(
  parameter int BUFFER_DEPTH = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [7:0]        dac_level,
  input  logic [7:0]        volume,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] audio_sample,
  output logic [1:0]        status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [10:0]       cfg_data
);

  logic [10:0]        fill_target;
  logic               q_full;
  logic               q_wr;
  afar_pkg::item_t    wr_item;
  logic               q_valid;
  logic               q_pop;
  afar_pkg::item_t    rd_item;
  afar_pkg::status_t  res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_target <= afar_pkg::TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fill_target <= cfg_data;
    end
  end

  afar_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .dac_level (dac_level),
    .volume    (volume),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (wr_item)
  );

  afar_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_item (rd_item)
  );

  afar_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fill_target (fill_target),
    .q_valid     (q_valid),
    .q_item      (rd_item),
    .q_pop       (q_pop),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res_sample  (audio_sample),
    .res_status  (res_status)
  );

  assign status = res_status;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CHOKE_CYCLES = 400;

  typedef struct {
    logic       kind;
    logic [7:0] lvl;
    logic [7:0] vol;
  } req_item_t;

  typedef struct {
    logic signed [9:0]   sample;
    afar_pkg::status_t   status;
  } sample_result_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [7:0] dac_level = 8'd0;
  logic [7:0] volume = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [9:0] audio_sample;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = 11'd0;

  // resampler shadow state
  int          ring [0:2047];
  logic [10:0] wr_ptr = '0;
  logic [10:0] rd_ptr = '0;
  logic        playing = 1'b0;
  int          held_q = 0;
  int          phase_q = 0;
  int          step_q = int'(afar_pkg::UNITY_STEP);
  logic [5:0]  adapt_cnt = '0;
  logic [10:0] target_q = afar_pkg::TARGET_RESET;

  req_item_t      pending_reqs[$];
  sample_result_t pending_samples[$];
  req_item_t      next_req;

  logic gappy = 1'b1;
  logic choke = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  int   errors = 0;
  int   items_sent = 0;
  int   status_seen [0:3] = '{0, 0, 0, 0};
  int   cycle_count = 0;

  audio_fifo_adaptive_resampler_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .dac_level    (dac_level),
    .volume       (volume),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .audio_sample (audio_sample),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int queued_now();
    logic [10:0] d;
    d = wr_ptr - rd_ptr;
    return d;
  endfunction

  task automatic predict_sample(input logic kind, input logic [7:0] lvl, input logic [7:0] vol);
    sample_result_t r;
    logic [10:0] nxt;
    int fill, att, scaled, corr, e0, e1;
    r.sample = '0;
    r.status = afar_pkg::STAT_OK;
    fill = queued_now();
    if (kind == REQ_PUSH) begin
      nxt = wr_ptr + 11'd1;
      att = (vol[7:4] < vol[3:0]) ? vol[7:4] : vol[3:0];
      if (nxt == rd_ptr) begin
        r.status = afar_pkg::STAT_FULL;
      end else begin
        scaled = (int'(lvl) - int'(afar_pkg::SILENCE_LEVEL)) * 4;
        ring[wr_ptr] = scaled * (16 - att) / 16;
        wr_ptr = nxt;
      end
    end else if (!playing && fill < int'(target_q)) begin
      r.status = afar_pkg::STAT_PRIMING;
    end else begin
      playing = 1'b1;
      if (fill < 2) begin
        r.sample = held_q[9:0];
        r.status = afar_pkg::STAT_UNDERRUN;
      end else begin
        if (adapt_cnt == 6'd0) begin
          corr = (fill - int'(target_q)) * 8;
          if (corr > afar_pkg::CORR_LIMIT) corr = afar_pkg::CORR_LIMIT;
          if (corr < -afar_pkg::CORR_LIMIT) corr = -afar_pkg::CORR_LIMIT;
          step_q = step_q + (int'(afar_pkg::UNITY_STEP) + corr - step_q) / 16;
        end
        adapt_cnt = adapt_cnt + 6'd1;
        e0 = ring[rd_ptr];
        e1 = ring[rd_ptr + 11'd1];
        held_q = e0 + (e1 - e0) * phase_q / 65536;
        // advance by the integer part, keep the fraction
        phase_q = phase_q + step_q;
        rd_ptr = rd_ptr + 11'(phase_q >> 16);
        phase_q = phase_q & 'hFFFF;
        r.sample = held_q[9:0];
      end
    end
    pending_samples.push_back(r);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sample(req_type, dac_level, volume);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tx_wait != 0 && !choke) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= next_req.kind;
          dac_level <= next_req.lvl;
          volume <= next_req.vol;
          tx_wait <= gappy ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    sample_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        status_seen[status]++;
        if (pending_samples.size() == 0) begin
          $display("%0t: result with none expected: audio_sample %0d status %0d",
                   $time, audio_sample, status);
          errors++;
        end else begin
          want = pending_samples.pop_front();
          if (audio_sample !== want.sample) begin
            $display("%0t: audio_sample expected %0d actual %0d",
                     $time, want.sample, audio_sample);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
        end
      end
      if (choke) begin
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready && gappy) rx_wait <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_samples.size());
      $display("[audio_fifo_adaptive_resampler_core] ERROR");
      $finish;
    end
  end

  task automatic add_fixed(input logic kind, input logic [7:0] lvl, input logic [7:0] vol);
    req_item_t it;
    it.kind = kind;
    it.lvl = lvl;
    it.vol = vol;
    pending_reqs.push_back(it);
  endtask

  task automatic add_req(input logic kind);
    add_fixed(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // wait until every item is in and every result is out
  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || pending_samples.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_target(input logic [10:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    target_q = value;
    @(negedge clk);
  endtask

  initial begin
    int est, tgt;
    logic kind;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // priming at the reset target, pushes at level and attenuation extremes
    add_fixed(REQ_PULL, 8'd0, 8'd0);
    add_fixed(REQ_PUSH, 8'd0, 8'h00);
    add_fixed(REQ_PUSH, 8'd255, 8'h00);
    add_fixed(REQ_PUSH, 8'd128, 8'h5A);
    add_fixed(REQ_PUSH, 8'd1, 8'hFF);
    add_fixed(REQ_PUSH, 8'd254, 8'hF3);
    add_fixed(REQ_PUSH, 8'd127, 8'h3F);
    add_fixed(REQ_PUSH, 8'd129, 8'h80);
    add_fixed(REQ_PUSH, 8'd0, 8'h0F);
    add_fixed(REQ_PULL, 8'd255, 8'hFF);
    settle();

    // zero target starts playback at once; drain into underrun
    write_target(11'd0);
    repeat (8) add_fixed(REQ_PULL, 8'd0, 8'd0);
    add_fixed(REQ_PUSH, 8'd200, 8'h11);
    add_fixed(REQ_PULL, 8'd0, 8'd0);
    add_fixed(REQ_PUSH, 8'd60, 8'h22);
    add_fixed(REQ_PULL, 8'd0, 8'd0);
    settle();

    // random traffic that hovers around each target
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: tgt = 1;
        1: tgt = 2;
        6: tgt = $urandom_range(100, 300);
        default: tgt = $urandom_range(3, 64);
      endcase
      write_target(11'(tgt));
      gappy = ($urandom_range(0, 3) != 0);
      est = queued_now();
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(0, 99) < 15) kind = 1'($urandom_range(0, 1));
        else if (est > tgt) kind = ($urandom_range(0, 99) < 65) ? REQ_PULL : REQ_PUSH;
        else kind = ($urandom_range(0, 99) < 35) ? REQ_PULL : REQ_PUSH;
        add_req(kind);
        if (kind == REQ_PULL) begin
          if (est > 0) est--;
        end else begin
          est++;
        end
      end
      if (p == 2) begin
        // hold off the receiver while the sender keeps offering
        fork
          begin
            choke <= 1'b1;
            repeat (CHOKE_CYCLES) @(posedge clk);
            choke <= 1'b0;
          end
        join_none
      end
      settle();
    end

    // top target: low fill drives the negative clamp
    write_target(11'd2047);
    gappy = 1'b1;
    for (int i = 0; i < 34; i++) begin
      add_req(REQ_PUSH);
      add_req(REQ_PUSH);
      add_req(REQ_PULL);
    end
    settle();

    // zero target with a queued backlog, then drain
    write_target(11'd0);
    for (int i = 0; i < 90; i++) add_req(($urandom_range(0, 9) < 6) ? REQ_PULL : REQ_PUSH);
    settle();
    repeat (20) @(posedge clk);

    $display("Sent %0d items over targets 0 to 2047, with priming, underrun and a long stall.",
             items_sent);
    $display("Results: %0d ok, %0d dropped on full, %0d underrun, %0d priming.",
             status_seen[afar_pkg::STAT_OK], status_seen[afar_pkg::STAT_FULL],
             status_seen[afar_pkg::STAT_UNDERRUN], status_seen[afar_pkg::STAT_PRIMING]);
    if (errors == 0) begin
      $display("[audio_fifo_adaptive_resampler_core] OK");
    end else begin
      $display("[audio_fifo_adaptive_resampler_core] ERROR");
    end
    $finish;
  end

endmodule
